// ===== sv/drrd_pkg.sv =====
`timescale 1ns / 1ps

package drrd_pkg;

    // Stream widths
    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_USER_W = 3;

    // Register port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register indexes, taken from paddr[2]
    localparam logic REG_ROW_BYTES  = 1'b0;
    localparam logic REG_BLOCK_ROWS = 1'b1;

    localparam logic [9:0]  ROW_BYTES_RST  = 10'd64;
    localparam logic [15:0] BLOCK_ROWS_RST = 16'd1;

    // Error codes
    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_ROW_END   = 2'd1,
        ERR_COUNT_OUT = 2'd2
    } t_err;

    localparam logic [4:0] SKIP_EXT  = 5'h1f;
    localparam logic [7:0] BYTE_FULL = 8'hff;

endpackage

// ===== sv/delta_row_raster_decoder.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Contents
// s_axis    in   tdata[7:0] in_byte; tuser[0] new_image
// m_axis    out  tdata[63:0] row_word, [67:64] valid_bytes; tlast last_of_row;
//                tuser[0] last_of_block, [2:1] error_code
// APB       in   0x0 row_bytes (10 bits), 0x4 block_rows (16 bits)
//
// One compressed byte is taken per cycle while parsing and the output register
// is free. A finished row is read out of the seed memory one 64-bit word per
// cycle while the output is free, paced by the single read port; no byte is
// taken meanwhile. Reset and new_image start a clearing pass over the seed
// memory, during which no byte is taken.
// A stalled output word holds in the output register and stalls the input.

module delta_row_raster_decoder #(
    parameter int MAX_ROW_BYTES = 512
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [drrd_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // [7:0] in_byte
    input  logic [drrd_pkg::IN_USER_W-1:0]    s_axis_tuser,  // [0] new_image
    // output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [drrd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // [63:0] row_word,
                                                             // [67:64] valid_bytes
    output logic                              m_axis_tlast,
    output logic [drrd_pkg::OUT_USER_W-1:0]   m_axis_tuser,  // [0] last_of_block,
                                                             // [2:1] error_code
    // register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [drrd_pkg::PADDR_W-1:0]      paddr,
    input  logic [drrd_pkg::PDATA_W-1:0]      pwdata,
    output logic [drrd_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    import drrd_pkg::*;

    localparam int RBW   = $clog2(MAX_ROW_BYTES + 1);   // holds 0..MAX_ROW_BYTES
    localparam int DEPTH = (MAX_ROW_BYTES + 7) / 8;     // 64-bit words of a row
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SKW   = (RBW > 8) ? RBW : 8;         // skip accumulator
    localparam int CW    = (RBW > 10) ? RBW : 10;       // row_bytes compare

    localparam logic [SKW:0]  MAX_S   = (SKW + 1)'(MAX_ROW_BYTES);
    localparam logic [CW-1:0] MAX_C   = CW'(MAX_ROW_BYTES);
    localparam logic [AW-1:0] LAST_AD = AW'(DEPTH - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_PARSE,
        ST_EMIT
    } t_state;

    typedef enum logic [2:0] {
        PH_CNT_LO,
        PH_CNT_HI,
        PH_CMD,
        PH_SKIP,
        PH_COPY
    } t_phase;

    // seed row, eight columns to a word
    logic [63:0] mem [DEPTH];

    t_state          r_st, n_st;
    t_phase          r_phase, n_phase;
    logic [7:0]      r_count_low, n_count_low;
    logic [15:0]     r_bytes_left, n_bytes_left;
    logic [3:0]      r_copy_left, n_copy_left;
    logic [SKW-1:0]  r_skip, n_skip;
    logic [RBW-1:0]  r_column, n_column;
    logic [15:0]     r_rows_done, n_rows_done;
    logic            r_failed, n_failed;
    logic            r_blk, n_blk;
    logic [AW-1:0]   r_clr_addr, n_clr_addr;
    logic [AW-1:0]   r_rd_addr, n_rd_addr;
    logic [9:0]      r_row_bytes;
    logic [15:0]     r_block_rows;

    logic            r_out_valid, n_out_valid;
    logic [3:0]      r_out_vbytes, n_out_vbytes;
    logic            r_out_lrow, n_out_lrow;
    logic            r_out_lblk, n_out_lblk;
    t_err            r_out_err, n_out_err;
    logic [63:0]     r_rd_data;

    logic            out_free;
    logic            in_acc;
    logic            cfg_wr;
    logic [7:0]      in_byte;
    logic [CW-1:0]   rb_ext;
    logic [RBW-1:0]  rb_eff;
    logic [RBW-1:0]  rb_m1;
    logic [AW-1:0]   last_addr;
    logic [3:0]      tail_bytes;
    logic [15:0]     br_eff;
    logic [15:0]     bl_dec;
    logic [15:0]     rows_inc;
    logic [SKW:0]    skip_sum;
    logic [SKW-1:0]  skip_sat;
    logic [SKW-1:0]  skip_amt;
    logic [SKW:0]    col_sum;
    logic [SKW:0]    rb_s;
    logic            do_skip;
    logic            do_finish;
    logic            do_error;
    t_err            err_code;
    logic            wr_en;
    logic            rd_en;
    logic            clr_en;
    logic [AW-1:0]   wr_addr;
    logic [2:0]      wr_lane;
    logic [63:0]     row_word;

    assign in_byte  = s_axis_tdata[7:0];
    assign out_free = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_st == ST_PARSE) && out_free;
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    // effective row length: zero taken as one, clip to the memory size
    always_comb begin
        rb_ext = CW'(r_row_bytes);
        if (rb_ext == '0) begin
            rb_eff = RBW'(1);
        end else if (rb_ext > MAX_C) begin
            rb_eff = RBW'(MAX_ROW_BYTES);
        end else begin
            rb_eff = RBW'(rb_ext);
        end
    end

    assign rb_m1      = rb_eff - RBW'(1);
    assign last_addr  = AW'(rb_m1 >> 3);
    assign tail_bytes = {1'b0, rb_m1[2:0]} + 4'd1;
    assign br_eff     = (r_block_rows == '0) ? 16'd1 : r_block_rows;
    assign bl_dec     = r_bytes_left - 16'd1;
    assign rows_inc   = r_rows_done + 16'd1;
    assign rb_s       = (SKW + 1)'(rb_eff);

    // skip extension: add and saturate at the memory size
    assign skip_sum = {1'b0, r_skip} + (SKW + 1)'(in_byte);
    assign skip_sat = (skip_sum > MAX_S) ? SKW'(MAX_ROW_BYTES) : SKW'(skip_sum);

    // column advance, saturating at the row end
    always_comb begin
        if (r_phase == PH_CMD) begin
            skip_amt = SKW'(in_byte[4:0]);
        end else begin
            skip_amt = skip_sat;
        end
        col_sum = (SKW + 1)'(r_column) + {1'b0, skip_amt};
    end

    always_comb begin
        n_st         = r_st;
        n_phase      = r_phase;
        n_count_low  = r_count_low;
        n_bytes_left = r_bytes_left;
        n_copy_left  = r_copy_left;
        n_skip       = r_skip;
        n_column     = r_column;
        n_rows_done  = r_rows_done;
        n_failed     = r_failed;
        n_blk        = r_blk;
        n_clr_addr   = r_clr_addr;
        n_rd_addr    = r_rd_addr;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_vbytes = r_out_vbytes;
        n_out_lrow   = r_out_lrow;
        n_out_lblk   = r_out_lblk;
        n_out_err    = r_out_err;
        do_skip      = 1'b0;
        do_finish    = 1'b0;
        do_error     = 1'b0;
        err_code     = ERR_NONE;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        clr_en       = 1'b0;
        wr_addr      = AW'(r_column >> 3);
        wr_lane      = r_column[2:0];

        case (r_st)
            ST_CLEAR: begin
                clr_en = 1'b1;
                if (r_clr_addr == LAST_AD) begin
                    n_st = ST_PARSE;
                end else begin
                    n_clr_addr = r_clr_addr + AW'(1);
                end
            end

            ST_PARSE: begin
                if (in_acc && s_axis_tuser[0]) begin
                    // new image: this byte is the count low byte of the first row
                    n_phase      = PH_CNT_HI;
                    n_count_low  = in_byte;
                    n_bytes_left = '0;
                    n_copy_left  = '0;
                    n_skip       = '0;
                    n_column     = '0;
                    n_rows_done  = '0;
                    n_failed     = 1'b0;
                    n_clr_addr   = '0;
                    n_st         = ST_CLEAR;
                end else if (in_acc && !r_failed) begin
                    case (r_phase)
                        PH_CNT_LO: begin
                            n_count_low = in_byte;
                            n_phase     = PH_CNT_HI;
                        end
                        PH_CNT_HI: begin
                            n_bytes_left = {in_byte, r_count_low};
                            if ({in_byte, r_count_low} == 16'd0) begin
                                do_finish = 1'b1;
                            end else begin
                                n_phase = PH_CMD;
                            end
                        end
                        PH_CMD: begin
                            n_bytes_left = bl_dec;
                            if (bl_dec == '0) begin
                                do_error = 1'b1;
                                err_code = ERR_COUNT_OUT;
                            end else begin
                                n_copy_left = {1'b0, in_byte[7:5]} + 4'd1;
                                if (in_byte[4:0] == SKIP_EXT) begin
                                    n_skip  = SKW'(SKIP_EXT);
                                    n_phase = PH_SKIP;
                                end else begin
                                    do_skip = 1'b1;
                                    n_phase = PH_COPY;
                                end
                            end
                        end
                        PH_SKIP: begin
                            n_bytes_left = bl_dec;
                            if (bl_dec == '0) begin
                                do_error = 1'b1;
                                err_code = ERR_COUNT_OUT;
                            end else begin
                                n_skip = skip_sat;
                                if (in_byte != BYTE_FULL) begin
                                    do_skip = 1'b1;
                                    n_phase = PH_COPY;
                                end
                            end
                        end
                        PH_COPY: begin
                            if (r_column >= rb_eff) begin
                                do_error = 1'b1;
                                err_code = ERR_ROW_END;
                            end else begin
                                wr_en        = 1'b1;
                                n_column     = r_column + RBW'(1);
                                n_bytes_left = bl_dec;
                                n_copy_left  = r_copy_left - 4'd1;
                                if (bl_dec == '0) begin
                                    do_finish = 1'b1;
                                end else if (r_copy_left == 4'd1) begin
                                    n_phase = PH_CMD;
                                end
                            end
                        end
                        default: begin
                            n_phase = PH_CNT_LO;
                        end
                    endcase
                end

                if (do_skip) begin
                    n_column = (col_sum > rb_s) ? rb_eff : RBW'(col_sum);
                end

                // error word goes straight to the output register
                if (do_error) begin
                    n_failed     = 1'b1;
                    n_out_valid  = 1'b1;
                    n_out_vbytes = '0;
                    n_out_lrow   = 1'b0;
                    n_out_lblk   = 1'b0;
                    n_out_err    = err_code;
                end

                // row done: count it against the block and start the readout
                if (do_finish) begin
                    if (rows_inc >= br_eff) begin
                        n_blk       = 1'b1;
                        n_rows_done = '0;
                    end else begin
                        n_blk       = 1'b0;
                        n_rows_done = rows_inc;
                    end
                    n_column     = '0;
                    n_phase      = PH_CNT_LO;
                    n_copy_left  = '0;
                    n_skip       = '0;
                    n_bytes_left = '0;
                    n_rd_addr    = '0;
                    n_st         = ST_EMIT;
                end
            end

            ST_EMIT: begin
                // read data is registered together with the output word's flags
                if (out_free) begin
                    rd_en        = 1'b1;
                    n_out_valid  = 1'b1;
                    n_out_err    = ERR_NONE;
                    n_out_lrow   = (r_rd_addr == last_addr);
                    n_out_lblk   = (r_rd_addr == last_addr) && r_blk;
                    n_out_vbytes = (r_rd_addr == last_addr) ? tail_bytes : 4'd8;
                    if (r_rd_addr == last_addr) begin
                        n_st = ST_PARSE;
                    end else begin
                        n_rd_addr = r_rd_addr + AW'(1);
                    end
                end
            end

            default: begin
                n_st = ST_CLEAR;
            end
        endcase
    end

    // seed memory: byte-lane write, word clear, registered word read
    always_ff @(posedge i_clk) begin
        if (clr_en) begin
            mem[r_clr_addr] <= '0;
        end else if (wr_en) begin
            mem[wr_addr][{wr_lane, 3'b000} +: 8] <= in_byte;
        end
        if (rd_en) begin
            r_rd_data <= mem[r_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st         <= ST_CLEAR;
            r_phase      <= PH_CNT_LO;
            r_count_low  <= '0;
            r_bytes_left <= '0;
            r_copy_left  <= '0;
            r_skip       <= '0;
            r_column     <= '0;
            r_rows_done  <= '0;
            r_failed     <= 1'b0;
            r_blk        <= 1'b0;
            r_clr_addr   <= '0;
            r_rd_addr    <= '0;
            r_row_bytes  <= ROW_BYTES_RST;
            r_block_rows <= BLOCK_ROWS_RST;
            r_out_valid  <= 1'b0;
            r_out_vbytes <= '0;
            r_out_lrow   <= 1'b0;
            r_out_lblk   <= 1'b0;
            r_out_err    <= ERR_NONE;
        end else begin
            r_st         <= n_st;
            r_phase      <= n_phase;
            r_count_low  <= n_count_low;
            r_bytes_left <= n_bytes_left;
            r_copy_left  <= n_copy_left;
            r_skip       <= n_skip;
            r_column     <= n_column;
            r_rows_done  <= n_rows_done;
            r_failed     <= n_failed;
            r_blk        <= n_blk;
            r_clr_addr   <= n_clr_addr;
            r_rd_addr    <= n_rd_addr;
            r_out_valid  <= n_out_valid;
            r_out_vbytes <= n_out_vbytes;
            r_out_lrow   <= n_out_lrow;
            r_out_lblk   <= n_out_lblk;
            r_out_err    <= n_out_err;
            if (cfg_wr) begin
                case (paddr[2])
                    REG_ROW_BYTES:  r_row_bytes  <= pwdata[9:0];
                    REG_BLOCK_ROWS: r_block_rows <= pwdata[15:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        case (paddr[2])
            REG_ROW_BYTES:  prdata = PDATA_W'(r_row_bytes);
            REG_BLOCK_ROWS: prdata = PDATA_W'(r_block_rows);
            default:        prdata = '0;
        endcase
    end

    // drop bytes past the row end; an error word has no valid bytes
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            row_word[b*8 +: 8] = (4'(b) < r_out_vbytes) ? r_rd_data[b*8 +: 8] : 8'd0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out_vbytes, row_word};
    assign m_axis_tlast  = r_out_lrow;
    assign m_axis_tuser  = {r_out_err, r_out_lblk};

endmodule
